// File: hw/rtl/dccr_pkg.sv
// shared types and constants for the dilated causal convolution block
`timescale 1ns / 1ps
package dccr_pkg;

  // command codes carried in the input tuser
  typedef enum logic [1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_WEIGHT = 2'd1,
    CMD_BIAS   = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int IN_TDATA_W  = 88;
  localparam int OUT_TDATA_W = 56;

  // one classified operation handed from the front end to the engine
  typedef struct packed {
    cmd_t        cmd;
    logic        store;
    logic        compute;
    logic [5:0]  ich;
    logic [5:0]  och;
    logic [2:0]  tap;
    logic [31:0] data;
  } op_t;

  // configuration after range clamping
  typedef struct packed {
    logic [3:0]         kt;
    logic [6:0]         dl;
    logic [6:0]         ic;
    logic [6:0]         oc;
    logic signed [31:0] mult;
    logic signed [6:0]  sh;
  } cfg_t;

endpackage

// File: hw/rtl/dccr_front.sv
// front end: configuration registers, input decode and operation classification
`timescale 1ns / 1ps
module dccr_front #(
  parameter int MAX_IN_CH  = 64,
  parameter int MAX_OUT_CH = 64,
  parameter int MAX_KERNEL = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [dccr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dccr_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [dccr_pkg::IN_TDATA_W-1:0] in_tdata,
  input  logic [1:0]                     in_tuser,
  output logic                           op_push,
  output dccr_pkg::op_t                  op_data,
  input  logic                           q_full,
  output dccr_pkg::cfg_t                 cfg_o
);

  localparam logic [dccr_pkg::CFG_IDX_W-1:0] REG_KT    = 3'd0;
  localparam logic [dccr_pkg::CFG_IDX_W-1:0] REG_DL    = 3'd1;
  localparam logic [dccr_pkg::CFG_IDX_W-1:0] REG_IC    = 3'd2;
  localparam logic [dccr_pkg::CFG_IDX_W-1:0] REG_OC    = 3'd3;
  localparam logic [dccr_pkg::CFG_IDX_W-1:0] REG_MULT  = 3'd4;
  localparam logic [dccr_pkg::CFG_IDX_W-1:0] REG_SHIFT = 3'd5;

  logic [3:0]         kt_r;
  logic [6:0]         dl_r;
  logic [6:0]         ic_r;
  logic [6:0]         oc_r;
  logic signed [31:0] mult_r;
  logic signed [6:0]  sh_r;

  dccr_pkg::cmd_t cmd;
  logic [5:0]     ich;
  logic [5:0]     och;
  logic [2:0]     tap;
  logic [31:0]    sample_v;
  logic [7:0]     weight_v;
  logic [31:0]    bias_v;
  logic           keep;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kt_r   <= 4'd1;
      dl_r   <= 7'd1;
      ic_r   <= 7'd1;
      oc_r   <= 7'd1;
      mult_r <= 32'sd1;
      sh_r   <= 7'sd0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KT:    kt_r   <= cfg_wdata[3:0];
        REG_DL:    dl_r   <= cfg_wdata[6:0];
        REG_IC:    ic_r   <= cfg_wdata[6:0];
        REG_OC:    oc_r   <= cfg_wdata[6:0];
        REG_MULT:  mult_r <= cfg_wdata[31:0];
        REG_SHIFT: sh_r   <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  // clamp registers into their working ranges
  always_comb begin
    cfg_o = '0;
    if (kt_r == 4'd0) cfg_o.kt = 4'd1;
    else if (kt_r > MAX_KERNEL) cfg_o.kt = 4'(MAX_KERNEL);
    else cfg_o.kt = kt_r;
    if (dl_r == 7'd0) cfg_o.dl = 7'd1;
    else if (dl_r > 7'd64) cfg_o.dl = 7'd64;
    else cfg_o.dl = dl_r;
    if (ic_r == 7'd0) cfg_o.ic = 7'd1;
    else if (ic_r > MAX_IN_CH) cfg_o.ic = 7'(MAX_IN_CH);
    else cfg_o.ic = ic_r;
    if (oc_r == 7'd0) cfg_o.oc = 7'd1;
    else if (oc_r > MAX_OUT_CH) cfg_o.oc = 7'(MAX_OUT_CH);
    else cfg_o.oc = oc_r;
    cfg_o.mult = mult_r;
    cfg_o.sh   = (sh_r < -7'sd31) ? -7'sd31 : sh_r;
  end

  // unpack the input transaction
  assign cmd      = dccr_pkg::cmd_t'(in_tuser);
  assign ich      = in_tdata[5:0];
  assign och      = in_tdata[11:6];
  assign tap      = in_tdata[14:12];
  assign sample_v = in_tdata[46:15];
  assign weight_v = in_tdata[54:47];
  assign bias_v   = in_tdata[86:55];

  // classify and drop writes that fall outside the memories
  always_comb begin
    op_data         = '0;
    op_data.cmd     = cmd;
    op_data.ich     = ich;
    op_data.och     = och;
    op_data.tap     = tap;
    op_data.store   = 32'(ich) < MAX_IN_CH;
    op_data.compute = {1'b0, ich} == (cfg_o.ic - 7'd1);
    keep            = 1'b1;
    case (cmd)
      dccr_pkg::CMD_SAMPLE: op_data.data = sample_v;
      dccr_pkg::CMD_WEIGHT: begin
        op_data.data = {{24{weight_v[7]}}, weight_v};
        keep = (32'(ich) < MAX_IN_CH) && (32'(och) < MAX_OUT_CH) &&
               (32'(tap) < MAX_KERNEL);
      end
      dccr_pkg::CMD_BIAS: begin
        op_data.data = bias_v;
        keep = 32'(och) < MAX_OUT_CH;
      end
      default: op_data.data = '0;
    endcase
  end

  assign in_tready = !q_full;
  assign op_push   = in_tvalid && in_tready && keep;

endmodule

// File: hw/rtl/dccr_opq.sv
// short operation queue between the front end and the engine
`timescale 1ns / 1ps
module dccr_opq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  dccr_pkg::op_t push_op,
  output logic          full,
  input  logic          pop,
  output dccr_pkg::op_t head,
  output logic          head_valid
);

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);

  dccr_pkg::op_t    mem_r [DEPTH];
  logic [PTR_W-1:0] wr_r;
  logic [PTR_W-1:0] rd_r;
  logic [PTR_W:0]   cnt_r;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + 1'b1;
      if (pop) rd_r <= rd_r + 1'b1;
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_op;
  end

  assign head       = mem_r[rd_r];
  assign head_valid = cnt_r != '0;
  assign full       = cnt_r == (PTR_W+1)'(DEPTH);

endmodule

// File: hw/rtl/dccr_engine.sv
// back end: memories, serial MAC loop, requantization and output register
`timescale 1ns / 1ps
module dccr_engine #(
  parameter int MAX_IN_CH     = 64,
  parameter int MAX_OUT_CH    = 64,
  parameter int MAX_KERNEL    = 8,
  parameter int HISTORY_DEPTH = 512
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  dccr_pkg::cfg_t                   cfg,
  input  dccr_pkg::op_t                    op,
  input  logic                             op_valid,
  output logic                             op_ready,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [dccr_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                             out_tlast
);

  localparam int HPW   = $clog2(HISTORY_DEPTH);
  localparam int SSW   = $clog2(HISTORY_DEPTH + 1);
  localparam int IW    = (MAX_IN_CH > 1) ? $clog2(MAX_IN_CH) : 1;
  localparam int OIW   = (MAX_OUT_CH > 1) ? $clog2(MAX_OUT_CH) : 1;
  localparam int KW    = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
  localparam int DLY_W = $clog2(MAX_KERNEL * 64);
  localparam int CW    = ((DLY_W > SSW) ? DLY_W : SSW) + 1;
  localparam int ACC_W = 41 + $clog2(MAX_KERNEL * MAX_IN_CH);
  localparam int PW    = ACC_W + 32;
  localparam int TW    = PW + 32;
  localparam logic [60:0] MAG_CAP = 61'd1 << 60;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MAC, ST_DRAIN, ST_MUL, ST_SUM, ST_RND, ST_SHF, ST_BIAS, ST_EMIT
  } state_t;

  state_t state_r;

  logic signed [31:0] hmem [HISTORY_DEPTH][MAX_IN_CH];
  logic signed [7:0]  wmem [MAX_OUT_CH][MAX_IN_CH][MAX_KERNEL];
  logic signed [31:0] bmem [MAX_OUT_CH];

  logic [6:0]       o_r;
  logic [6:0]       i_r;
  logic [3:0]       k_r;
  logic [DLY_W-1:0] delay_r;
  logic [HPW-1:0]   wp_r;
  logic [SSW-1:0]   steps_r;
  logic             v1_r;
  logic             v2_r;

  logic signed [31:0]      hq_r;
  logic signed [7:0]       wq_r;
  logic signed [31:0]      bq_r;
  logic signed [39:0]      prod_r;
  logic signed [ACC_W-1:0] acc_r;
  logic                    neg_r;
  logic [63:0]             p0_r;
  logic [ACC_W-1:0]        p1_r;
  logic [PW-1:0]           p_r;
  logic [PW:0]             r_r;
  logic [60:0]             mag_r;
  logic [47:0]             res_r;
  logic                    out_valid_r;
  logic [5:0]              out_idx_r;
  logic [47:0]             out_val_r;
  logic                    out_last_r;

  logic             pop;
  logic             tap_ok;
  logic [CW-1:0]    slot_w;
  logic [HPW-1:0]   slot;
  logic             last_i;
  logic             last_k;
  logic             last_o;
  logic [DLY_W-1:0] dly_init;
  logic             start_ch;
  logic             emit_fire;
  logic [ACC_W-1:0] amag;
  logic [31:0]      mmag;
  logic             sh_pos;
  logic [4:0]       lsh;
  logic [TW-1:0]    shf;
  logic [61:0]      sv;
  logic [62:0]      sum;

  assign pop       = op_valid && (state_r == ST_IDLE);
  assign op_ready  = state_r == ST_IDLE;
  assign last_i    = i_r == (cfg.ic - 7'd1);
  assign last_k    = k_r == (cfg.kt - 4'd1);
  assign last_o    = o_r == (cfg.oc - 7'd1);
  assign dly_init  = DLY_W'((11'(cfg.kt) - 11'd1) * 11'(cfg.dl));
  assign emit_fire = (state_r == ST_EMIT) && (!out_valid_r || out_tready);
  assign start_ch  = (pop && op.cmd == dccr_pkg::CMD_SAMPLE && op.compute) ||
                     (emit_fire && !last_o);

  // tap validity and ring slot of the current tap
  always_comb begin
    tap_ok = (CW'(delay_r) <= CW'(steps_r)) && (CW'(delay_r) < CW'(HISTORY_DEPTH));
    if (CW'(wp_r) >= CW'(delay_r)) slot_w = CW'(wp_r) - CW'(delay_r);
    else slot_w = CW'(wp_r) + CW'(HISTORY_DEPTH) - CW'(delay_r);
    slot = HPW'(slot_w);
  end

  // requantization datapath pieces
  always_comb begin
    amag   = acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);
    mmag   = cfg.mult[31] ? 32'(-cfg.mult) : 32'(cfg.mult);
    sh_pos = !cfg.sh[6] && (cfg.sh != 7'sd0);
    lsh    = 5'(-cfg.sh);
    if (sh_pos) shf = TW'(r_r >> cfg.sh[5:0]);
    else shf = TW'(r_r) << lsh;
    sv  = neg_r ? -{1'b0, mag_r} : {1'b0, mag_r};
    sum = {sv[61], sv} + {{31{bq_r[31]}}, bq_r};
  end

  // sequencer, ring pointer and output handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      o_r         <= '0;
      i_r         <= '0;
      k_r         <= '0;
      delay_r     <= '0;
      wp_r        <= '0;
      steps_r     <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r <= (state_r == ST_MAC) && tap_ok;
      v2_r <= v1_r;
      if (emit_fire) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
      if (start_ch) begin
        i_r     <= '0;
        k_r     <= '0;
        delay_r <= dly_init;
      end
      case (state_r)
        ST_IDLE: begin
          if (op_valid) begin
            case (op.cmd)
              dccr_pkg::CMD_SAMPLE: begin
                if (op.compute) begin
                  o_r     <= '0;
                  state_r <= ST_MAC;
                end
              end
              dccr_pkg::CMD_CLEAR: begin
                wp_r    <= '0;
                steps_r <= '0;
              end
              default: ;
            endcase
          end
        end
        ST_MAC: begin
          if (last_i) begin
            i_r     <= '0;
            k_r     <= k_r + 4'd1;
            delay_r <= delay_r - DLY_W'(cfg.dl);
            if (last_k) state_r <= ST_DRAIN;
          end else begin
            i_r <= i_r + 7'd1;
          end
        end
        ST_DRAIN: if (!v1_r && !v2_r) state_r <= ST_MUL;
        ST_MUL:   state_r <= ST_SUM;
        ST_SUM:   state_r <= ST_RND;
        ST_RND:   state_r <= ST_SHF;
        ST_SHF:   state_r <= ST_BIAS;
        ST_BIAS:  state_r <= ST_EMIT;
        ST_EMIT: begin
          if (emit_fire) begin
            if (last_o) begin
              state_r <= ST_IDLE;
              wp_r    <= (wp_r == HPW'(HISTORY_DEPTH - 1)) ? '0 : wp_r + 1'b1;
              if (CW'(steps_r) < CW'(HISTORY_DEPTH)) steps_r <= steps_r + 1'b1;
            end else begin
              o_r     <= o_r + 7'd1;
              state_r <= ST_MAC;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // memories and arithmetic pipeline
  always_ff @(posedge clk) begin
    if (pop) begin
      case (op.cmd)
        dccr_pkg::CMD_SAMPLE: if (op.store) hmem[wp_r][IW'(op.ich)] <= op.data;
        dccr_pkg::CMD_WEIGHT: wmem[OIW'(op.och)][IW'(op.ich)][KW'(op.tap)] <= op.data[7:0];
        dccr_pkg::CMD_BIAS:   bmem[OIW'(op.och)] <= op.data;
        default: ;
      endcase
    end
    hq_r   <= hmem[slot][IW'(i_r)];
    wq_r   <= wmem[OIW'(o_r)][IW'(i_r)][KW'(k_r)];
    bq_r   <= bmem[OIW'(o_r)];
    prod_r <= wq_r * hq_r;
    if (start_ch) acc_r <= '0;
    else if (v2_r) acc_r <= acc_r + ACC_W'(prod_r);
    // partial products of the magnitude
    neg_r <= acc_r[ACC_W-1] ^ cfg.mult[31];
    p0_r  <= amag[31:0] * mmag;
    p1_r  <= amag[ACC_W-1:32] * mmag;
    p_r   <= PW'(p0_r) + (PW'(p1_r) << 32);
    // round half away from zero on the magnitude
    if (sh_pos) r_r <= (PW+1)'(p_r) + ((PW+1)'(1) << (cfg.sh[5:0] - 6'd1));
    else r_r <= (PW+1)'(p_r);
    mag_r <= (shf > TW'(MAG_CAP)) ? MAG_CAP : shf[60:0];
    // bias and 48-bit saturation
    if (sum[62:47] == {16{sum[47]}}) res_r <= sum[47:0];
    else if (sum[62]) res_r <= 48'h8000_0000_0000;
    else res_r <= 48'h7FFF_FFFF_FFFF;
    if (emit_fire) begin
      out_idx_r  <= 6'(o_r);
      out_val_r  <= res_r;
      out_last_r <= last_o;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_val_r, out_idx_r};
  assign out_tlast  = out_last_r;

  a_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL) |-> (!v1_r && !v2_r))
    else $error("requant started with MAC pipeline busy");
  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> (out_idx_r == 6'(cfg.oc - 7'd1)))
    else $error("last flag on wrong output channel");
  a_steps: assert property (@(posedge clk) disable iff (!rst_n)
    CW'(steps_r) <= CW'(HISTORY_DEPTH))
    else $error("step count beyond history depth");
  a_emit: assert property (@(posedge clk) disable iff (!rst_n)
    emit_fire |=> out_valid_r)
    else $error("emitted result not presented");

endmodule

// File: hw/rtl/dilated_causal_conv_requant.sv
// a step-completing sample leaves the queue and starts the MAC loop over every tap and input channel
// for each output channel in turn, set by the single MAC and followed by the requant stages
// other commands retire without leaving the idle state; the input takes one transaction per cycle
// until the four-entry operation queue fills
// reset: rst_n synchronous active low returns config to its defaults and clears queue, sequencer and ring pointer;
// history, weight and bias memories are undefined until written
`timescale 1ns / 1ps
module dilated_causal_conv_requant #(
  parameter int MAX_IN_CH     = 64,
  parameter int MAX_OUT_CH    = 64,
  parameter int MAX_KERNEL    = 8,
  parameter int HISTORY_DEPTH = 512
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [dccr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dccr_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // in_channel, out_channel, tap, sample_value, weight_value, bias_value, pad
  input  logic [dccr_pkg::IN_TDATA_W-1:0]  in_tdata,
  // command
  input  logic [1:0]                       in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // out_index, out_value, pad
  output logic [dccr_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                             out_tlast
);

  dccr_pkg::op_t  push_op;
  dccr_pkg::op_t  head;
  dccr_pkg::cfg_t cfg;
  logic           push;
  logic           full;
  logic           head_valid;
  logic           op_ready;

  dccr_front #(
    .MAX_IN_CH (MAX_IN_CH),
    .MAX_OUT_CH(MAX_OUT_CH),
    .MAX_KERNEL(MAX_KERNEL)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata (in_tdata),
    .in_tuser (in_tuser),
    .op_push  (push),
    .op_data  (push_op),
    .q_full   (full),
    .cfg_o    (cfg)
  );

  dccr_opq u_opq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_op   (push_op),
    .full      (full),
    .pop       (head_valid && op_ready),
    .head      (head),
    .head_valid(head_valid)
  );

  dccr_engine #(
    .MAX_IN_CH    (MAX_IN_CH),
    .MAX_OUT_CH   (MAX_OUT_CH),
    .MAX_KERNEL   (MAX_KERNEL),
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .op        (head),
    .op_valid  (head_valid),
    .op_ready  (op_ready),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

endmodule
